@@ rtl/dpsr_pkg.sv @@
// Shared definitions for the delay phase-slope rotator: widths, the request and
// response structs, the front-to-back item, and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package dpsr_pkg;

   localparam int SAMPLE_WIDTH        = 16;
   localparam int CHANNEL_BITS        = 14;
   localparam int DELAY_WIDTH         = 32;
   localparam int RES_WIDTH           = 32;
   localparam int TURN_WIDTH          = 32;
   localparam int FRAC_WIDTH          = 40;
   localparam int PHASE_BITS_DEFAULT  = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int CORDIC_STEPS        = 24;
   localparam int CORDIC_WIDTH        = 34;
   localparam int ROUND_SHIFT         = 30;

   localparam logic [RES_WIDTH-1:0]           RES_RESET   = 32'd1000000;
   localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

   typedef enum logic [1:0] {
      QUADRANT_0,
      QUADRANT_1,
      QUADRANT_2,
      QUADRANT_3
   } quadrant_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_re;
      logic signed [SAMPLE_WIDTH-1:0] sample_im;
      logic                           sample_valid;
      logic [CHANNEL_BITS-1:0]        channel;
      logic signed [DELAY_WIDTH-1:0]  delay_value;
      logic                           delay_valid;
   } dpsr_req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] out_re;
      logic signed [SAMPLE_WIDTH-1:0] out_im;
      logic                           out_valid;
   } dpsr_rsp_type;

   // What the front hands to the back: the sample, its flags, and the
   // phase already split into a quadrant and a residual angle.
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_re;
      logic signed [SAMPLE_WIDTH-1:0] sample_im;
      logic                           sample_valid;
      logic                           delay_valid;
      quadrant_type                   quadrant;
      logic signed [TURN_WIDTH-1:0]   residual;
   } dpsr_item_type;

   // Arctangent of 2^-step in units of 2^-32 turn.
   function automatic logic [TURN_WIDTH-1:0] atan_turn(input int unsigned step);
      logic [TURN_WIDTH-1:0] value;
      unique case (step)
         0:       value = 32'h20000000;
         1:       value = 32'h12E4051D;
         2:       value = 32'h09FB385B;
         3:       value = 32'h051111D4;
         4:       value = 32'h028B0D43;
         5:       value = 32'h0145D7E1;
         6:       value = 32'h00A2F61E;
         7:       value = 32'h00517C55;
         8:       value = 32'h0028BE53;
         9:       value = 32'h00145F2F;
         10:      value = 32'h000A2F98;
         11:      value = 32'h000517CC;
         12:      value = 32'h00028BE6;
         13:      value = 32'h000145F3;
         14:      value = 32'h0000A2F9;
         15:      value = 32'h0000517C;
         16:      value = 32'h000028BE;
         17:      value = 32'h0000145F;
         18:      value = 32'h00000A2F;
         19:      value = 32'h00000517;
         20:      value = 32'h0000028B;
         21:      value = 32'h00000145;
         22:      value = 32'h000000A2;
         23:      value = 32'h00000051;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

@@ rtl/delay_phase_slope_rotator_unit.sv @@
// Top level of the delay phase-slope rotator: configuration register, front,
// queue and back. Depends on dpsr_pkg, dpsr_front, dpsr_queue and dpsr_back.
`default_nettype none

// The unit rotates one complex Q1.15 sample by the phase that a delay implies
// at its spectral channel, resolution * delay * channel turns with the delay in
// units of 2^-40 s, and returns it rounded and saturated. When the delay is
// marked invalid the sample comes back unchanged and flagged invalid. A request
// transfers at a rising edge where start is high and busy is low; one result
// per request appears on rsp_data for exactly one cycle with rsp_strobe high,
// in request order. The receiver cannot hold results off, and the unit never
// needs it to: one request can transfer every cycle while busy is low. Each
// result passes through three front stages for the phase multiply and
// quadrant split, the queue, an entry register at the head of the back, 24
// CORDIC stages (one iteration each), a quadrant fold, a multiply stage and a
// round and saturate stage. Busy rises only if the queue could overflow, which
// the always-draining back never lets happen at the default depth. The channel
// resolution register is written with csr_write_enable and should be changed
// only while no result is outstanding.

module delay_phase_slope_rotator_unit #(
   parameter int PHASE_BITS  = dpsr_pkg::PHASE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = dpsr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire dpsr_pkg::dpsr_req_type         req_data,
   output logic                                rsp_strobe,
   output dpsr_pkg::dpsr_rsp_type              rsp_data,
   input  wire logic                           csr_write_enable,
   input  wire logic [dpsr_pkg::RES_WIDTH-1:0] csr_write_data
);
   import dpsr_pkg::*;

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int BUSY_W = $clog2(QUEUE_DEPTH + 4);

   // Channel resolution in hertz.
   logic [RES_WIDTH-1:0] resolution_ff, resolution_in;

   always_comb begin
      resolution_in = csr_write_enable ? csr_write_data : resolution_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff <= RES_RESET;
      end else begin
         resolution_ff <= resolution_in;
      end
   end

   logic          accept;
   logic          item_valid;
   dpsr_item_type item;
   logic [1:0]    inflight;
   logic          pop_valid;
   dpsr_item_type pop_item;
   logic [CNT_W-1:0]  queue_count;
   logic [BUSY_W-1:0] committed;

   // Items that will sit in the queue once this cycle's pop is done, plus the
   // ones still in the front, must leave room for one more transfer.
   always_comb begin
      committed = BUSY_W'(queue_count) - BUSY_W'(pop_valid) + BUSY_W'(inflight);
      busy      = (committed >= BUSY_W'(QUEUE_DEPTH));
      accept    = start && !busy;
   end

   dpsr_front #(
      .PHASE_BITS (PHASE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .resolution (resolution_ff),
      .item_valid (item_valid),
      .item       (item),
      .inflight   (inflight)
   );

   dpsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (item_valid),
      .push_item  (item),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .count      (queue_count)
   );

   dpsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pop_valid),
      .in_item    (pop_item),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/dpsr_front.sv @@
// Front part of the rotator: takes requests and turns the delay into a phase,
// split into quadrant and residual angle. Three register stages.
// Depends on dpsr_pkg.
`default_nettype none

module dpsr_front #(
   parameter int PHASE_BITS = dpsr_pkg::PHASE_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire dpsr_pkg::dpsr_req_type         req,
   input  wire logic [dpsr_pkg::RES_WIDTH-1:0] resolution,
   output logic                                item_valid,
   output dpsr_pkg::dpsr_item_type             item,
   output logic [1:0]                          inflight
);
   import dpsr_pkg::*;

   localparam int HI_WIDTH = FRAC_WIDTH - DELAY_WIDTH;
   localparam logic [TURN_WIDTH-1:0] TURN_MASK =
      ~((TURN_WIDTH'(1) << (TURN_WIDTH - PHASE_BITS)) - TURN_WIDTH'(1));
   localparam logic [TURN_WIDTH-1:0] EIGHTH_TURN = TURN_WIDTH'(1) << (TURN_WIDTH - 3);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   // Stage 1: resolution times delay, modulo 2^40.
   logic [2*RES_WIDTH-1:0]         prod_full;
   logic [HI_WIDTH-1:0]            prod_hi;
   logic [FRAC_WIDTH-1:0]          rd_ff, rd_in;
   logic signed [SAMPLE_WIDTH-1:0] re1_ff, im1_ff;
   logic                           sv1_ff, dv1_ff;
   logic [CHANNEL_BITS-1:0]        chan1_ff;

   // Stage 2: times channel, keep the turn word.
   logic [FRAC_WIDTH-1:0]          ph_in;
   logic [TURN_WIDTH-1:0]          turn_ff, turn_in;
   logic signed [SAMPLE_WIDTH-1:0] re2_ff, im2_ff;
   logic                           sv2_ff, dv2_ff;

   // Stage 3: quadrant and residual.
   logic [TURN_WIDTH-1:0]          shifted;
   quadrant_type                   quad;
   dpsr_item_type                  item_ff, item_in;

   always_comb begin
      prod_full = RES_WIDTH'(0) + (2*RES_WIDTH)'(resolution)
                  * (2*RES_WIDTH)'($unsigned(req.delay_value));
      // The sign extension of the delay adds minus the resolution at bit 32.
      prod_hi   = req.delay_value[DELAY_WIDTH-1] ? (HI_WIDTH'(0) - resolution[HI_WIDTH-1:0])
                                                 : HI_WIDTH'(0);
      rd_in     = prod_full[FRAC_WIDTH-1:0] + {prod_hi, DELAY_WIDTH'(0)};
      v1_in     = accept;
   end

   always_comb begin
      ph_in   = rd_ff * FRAC_WIDTH'(chan1_ff);
      turn_in = ph_in[FRAC_WIDTH-1 -: TURN_WIDTH] & TURN_MASK;
      v2_in   = v1_ff;
   end

   always_comb begin
      shifted              = turn_ff + EIGHTH_TURN;
      quad                 = quadrant_type'(shifted[TURN_WIDTH-1 -: 2]);
      item_in.sample_re    = re2_ff;
      item_in.sample_im    = im2_ff;
      item_in.sample_valid = sv2_ff;
      item_in.delay_valid  = dv2_ff;
      item_in.quadrant     = quad;
      item_in.residual     = $signed(turn_ff - {shifted[TURN_WIDTH-1 -: 2], (TURN_WIDTH-2)'(0)});
      v3_in                = v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff    <= rd_in;
         re1_ff   <= req.sample_re;
         im1_ff   <= req.sample_im;
         sv1_ff   <= req.sample_valid;
         dv1_ff   <= req.delay_valid;
         chan1_ff <= req.channel;
      end
      if (v1_ff) begin
         turn_ff <= turn_in;
         re2_ff  <= re1_ff;
         im2_ff  <= im1_ff;
         sv2_ff  <= sv1_ff;
         dv2_ff  <= dv1_ff;
      end
      if (v2_ff) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = v3_ff;
   assign item       = item_ff;
   assign inflight   = 2'(v1_ff) + 2'(v2_ff) + 2'(v3_ff);

endmodule

`default_nettype wire

@@ rtl/dpsr_queue.sv @@
// Short queue between the front and the back of the rotator. The back takes
// the head every cycle that the queue holds an item. Depends on dpsr_pkg.
`default_nettype none

module dpsr_queue #(
   parameter int DEPTH = dpsr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push_valid,
   input  wire dpsr_pkg::dpsr_item_type      push_item,
   output logic                              pop_valid,
   output dpsr_pkg::dpsr_item_type           pop_item,
   output logic [$clog2(DEPTH+1)-1:0]        count
);
   import dpsr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   dpsr_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   always_comb begin
      pop       = (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push_valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_valid = pop;
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

@@ rtl/dpsr_back.sv @@
// Back part of the rotator: pipelined CORDIC for cosine and sine, quadrant
// fold, complex multiply, rounding and saturation. Depends on dpsr_pkg.
`default_nettype none

module dpsr_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire dpsr_pkg::dpsr_item_type in_item,
   output logic                         rsp_strobe,
   output dpsr_pkg::dpsr_rsp_type       rsp_data
);
   import dpsr_pkg::*;

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CW    = CORDIC_WIDTH;
   localparam int PRW   = SW + CW;
   localparam int PW    = PRW + 1;
   localparam int STEPS = CORDIC_STEPS;

   localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (ROUND_SHIFT - 1);
   localparam logic signed [PW-1:0] SAT_HI     = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [PW-1:0] SAT_LO     = ~SAT_HI;

   typedef struct packed {
      logic signed [SW-1:0] sample_re;
      logic signed [SW-1:0] sample_im;
      logic                 sample_valid;
      logic                 delay_valid;
      quadrant_type         quadrant;
   } meta_type;

   function automatic logic signed [SW-1:0] saturate(input logic signed [PW-1:0] v);
      logic signed [SW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SW-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SW-1:0];
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   // CORDIC pipeline: entry 0 is loaded from the queue, entry i+1 after step i.
   logic                 v_ff [0:STEPS];
   meta_type             m_ff [0:STEPS];
   logic signed [CW-1:0] x_ff [0:STEPS];
   logic signed [CW-1:0] x_in [0:STEPS];
   logic signed [CW-1:0] y_ff [0:STEPS];
   logic signed [CW-1:0] y_in [0:STEPS];
   logic signed [CW-1:0] z_ff [0:STEPS];
   logic signed [CW-1:0] z_in [0:STEPS];

   always_comb begin
      x_in[0] = CORDIC_GAIN;
      y_in[0] = '0;
      z_in[0] = CW'(in_item.residual);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         m_ff[0].sample_re    <= in_item.sample_re;
         m_ff[0].sample_im    <= in_item.sample_im;
         m_ff[0].sample_valid <= in_item.sample_valid;
         m_ff[0].delay_valid  <= in_item.delay_valid;
         m_ff[0].quadrant     <= in_item.quadrant;
         x_ff[0]              <= x_in[0];
         y_ff[0]              <= y_in[0];
         z_ff[0]              <= z_in[0];
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [CW-1:0] ANGLE = CW'(atan_turn(i));

      always_comb begin
         if (z_ff[i][CW-1]) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + ANGLE;
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - ANGLE;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         m_ff[i+1] <= m_ff[i];
         x_ff[i+1] <= x_in[i+1];
         y_ff[i+1] <= y_in[i+1];
         z_ff[i+1] <= z_in[i+1];
      end
   end

   // Quadrant fold.
   logic                 vq_ff;
   meta_type             mq_ff;
   logic signed [CW-1:0] cos_ff, cos_in, sin_ff, sin_in;

   always_comb begin
      case (m_ff[STEPS].quadrant)
         QUADRANT_0: begin
            cos_in = x_ff[STEPS];
            sin_in = y_ff[STEPS];
         end
         QUADRANT_1: begin
            cos_in = -y_ff[STEPS];
            sin_in = x_ff[STEPS];
         end
         QUADRANT_2: begin
            cos_in = -x_ff[STEPS];
            sin_in = -y_ff[STEPS];
         end
         default: begin
            cos_in = y_ff[STEPS];
            sin_in = -x_ff[STEPS];
         end
      endcase
   end

   // Complex multiply, one register after the products.
   logic                  vp_ff;
   meta_type              mp_ff;
   logic signed [PRW-1:0] rc_ff, rc_in, is_ff, is_in, rs_ff, rs_in, ic_ff, ic_in;

   always_comb begin
      rc_in = mq_ff.sample_re * cos_ff;
      is_in = mq_ff.sample_im * sin_ff;
      rs_in = mq_ff.sample_re * sin_ff;
      ic_in = mq_ff.sample_im * cos_ff;
   end

   // Sum, round, saturate, and the bypass for an invalid delay.
   logic signed [PW-1:0] vr, vi;
   logic                 strobe_ff, strobe_in;
   dpsr_rsp_type         rsp_ff, rsp_in;

   always_comb begin
      vr        = (PW'(rc_ff) - PW'(is_ff) + ROUND_HALF) >>> ROUND_SHIFT;
      vi        = (PW'(rs_ff) + PW'(ic_ff) + ROUND_HALF) >>> ROUND_SHIFT;
      strobe_in = vp_ff;
      if (mp_ff.delay_valid) begin
         rsp_in.out_re    = saturate(vr);
         rsp_in.out_im    = saturate(vi);
         rsp_in.out_valid = mp_ff.sample_valid;
      end else begin
         rsp_in.out_re    = mp_ff.sample_re;
         rsp_in.out_im    = mp_ff.sample_im;
         rsp_in.out_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff     <= 1'b0;
         vp_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         vq_ff     <= v_ff[STEPS];
         vp_ff     <= vq_ff;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mq_ff  <= m_ff[STEPS];
      cos_ff <= cos_in;
      sin_ff <= sin_in;
      mp_ff  <= mq_ff;
      rc_ff  <= rc_in;
      is_ff  <= is_in;
      rs_ff  <= rs_in;
      ic_ff  <= ic_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire
